// ===== hw/rtl/lpmq_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmq_pkg
// Types and codes shared by the legacy POWER MQ arithmetic unit.
// ----------------------------------------------------------------------------
package lpmq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ActW  = 3;

  localparam logic [ActW-1:0] ACT_ABS    = 3'd0;
  localparam logic [ActW-1:0] ACT_NABS   = 3'd1;
  localparam logic [ActW-1:0] ACT_DOZ    = 3'd2;
  localparam logic [ActW-1:0] ACT_DIV    = 3'd3;
  localparam logic [ActW-1:0] ACT_DIVS   = 3'd4;
  localparam logic [ActW-1:0] ACT_MUL    = 3'd5;
  localparam logic [ActW-1:0] ACT_WR_MQ  = 3'd6;
  localparam logic [ActW-1:0] ACT_CLR_SO = 3'd7;

  localparam logic [WordW-1:0] SIGN_WORD = 32'h8000_0000;

  // CR0 bits
  localparam logic [3:0] CR_LT = 4'b1000;
  localparam logic [3:0] CR_GT = 4'b0100;
  localparam logic [3:0] CR_EQ = 4'b0010;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic             record_cr;
    logic             update_ov;
  } in_word_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic [3:0]       cr0;
    logic             overflow;
    logic             summary_overflow;
    logic [WordW-1:0] mq_value;
  } out_word_t;

endpackage

// ===== hw/rtl/legacy_power_mq_arith_unit.sv =====
// ----------------------------------------------------------------------------
// legacy_power_mq_arith_unit
// MQ-based POWER arithmetic: abs, nabs, doz, div, divs, mul, MQ load, SO clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_stall/in_data, one result word per input
//   word leaves on out_valid/out_stall/out_data. A word moves on a rising edge
//   with valid high and stall low.
//   in_stall is high while an operation is in progress. div and divs run a
//   restoring divider one quotient bit per cycle over the 64-bit dividend;
//   mul runs a shift-add multiplier one multiplier bit per cycle.
//   abs, nabs, doz, MQ load, SO clear and div, divs by a zero divisor go from
//   accept straight to the finish state; mul and the other div, divs pass
//   through the multiply or divide steps before it.
//   The next word is taken the cycle after the result is registered. The
//   result register holds its word while out_stall is high; a new word may be
//   accepted and worked on meanwhile, its finish waits for the register.
//   Reset clears MQ, OV, SO and leaves the unit idle with no result pending.
// ----------------------------------------------------------------------------
module legacy_power_mq_arith_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpmq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpmq_pkg::out_word_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int unsigned W = lpmq_pkg::WordW;

  logic [1:0]              state_r, state_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [lpmq_pkg::ActW-1:0] op_r;
  logic [W-1:0]            a_r, b_r;
  logic                    rec_r, upd_r, dneg_r, vneg_r, zdiv_r;
  logic [W-1:0]            rem_r, rem_nxt;
  logic [2*W-1:0]          dq_r, dq_nxt;
  logic [W-1:0]            mq_r, mq_nxt;
  logic                    ov_r, ov_nxt, so_r, so_nxt;
  logic                    out_valid_r;
  lpmq_pkg::out_word_t     out_r, out_nxt;

  logic                    accept, fin_go;
  logic [2*W-1:0]          dvd, dvd_mag;
  logic                    is_div, is_mul;
  logic [W:0]              trial, trial_diff, msum;
  logic                    ge;

  // finish-stage values
  logic [W-1:0]            res;
  logic                    op_ov, arith, qneg;
  logic [2*W-1:0]          prod;
  logic [3:0]              cr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign is_div   = (in_data.action == lpmq_pkg::ACT_DIV) ||
                    (in_data.action == lpmq_pkg::ACT_DIVS);
  assign is_mul   = (in_data.action == lpmq_pkg::ACT_MUL);

  // dividend: a:MQ for div, sign-extended a for divs
  assign dvd     = (in_data.action == lpmq_pkg::ACT_DIV) ? {in_data.operand_a, mq_r}
                 : {{W{in_data.operand_a[W-1]}}, in_data.operand_a};
  assign dvd_mag = dvd[2*W-1] ? (~dvd + 1'b1) : dvd;

  // one restoring-division step
  assign trial      = {rem_r, dq_r[2*W-1]};
  assign trial_diff = trial - {1'b0, b_r};
  assign ge         = (trial >= {1'b0, b_r});
  // one shift-add multiply step
  assign msum       = {1'b0, rem_r} + (dq_r[0] ? {1'b0, b_r} : '0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = '1;
          rem_nxt = '0;
          if (is_div) begin
            dq_nxt    = dvd_mag;
            state_nxt = (in_data.operand_b == '0) ? S_FIN : S_DIV;
          end else if (is_mul) begin
            dq_nxt    = {{W{1'b0}}, in_data.operand_a[W-1] ?
                         (~in_data.operand_a + 1'b1) : in_data.operand_a};
            cnt_nxt   = 6'(W - 1);
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        rem_nxt = ge ? trial_diff[W-1:0] : trial[W-1:0];
        dq_nxt  = {dq_r[2*W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_FIN;
      end
      S_MUL: begin
        rem_nxt       = msum[W:1];
        dq_nxt[W-1:0] = {msum[0], dq_r[W-1:1]};
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // finish: results, sign fix-up, overflow, flags, MQ and CR0
  always_comb begin
    res    = '0;
    op_ov  = 1'b0;
    arith  = 1'b1;
    mq_nxt = mq_r;
    so_nxt = so_r;
    ov_nxt = ov_r;
    qneg   = dneg_r ^ vneg_r;
    prod   = qneg ? (~{rem_r, dq_r[W-1:0]} + 1'b1) : {rem_r, dq_r[W-1:0]};
    case (op_r)
      lpmq_pkg::ACT_ABS: begin
        if (a_r == lpmq_pkg::SIGN_WORD) begin
          op_ov = 1'b1;
          res   = lpmq_pkg::SIGN_WORD;
        end else begin
          res = a_r[W-1] ? (~a_r + 1'b1) : a_r;
        end
      end
      lpmq_pkg::ACT_NABS: res = (a_r[W-1] || a_r == '0) ? a_r : (~a_r + 1'b1);
      lpmq_pkg::ACT_DOZ: begin
        if ($signed(a_r) >= $signed(b_r)) op_ov = (a_r == b_r);
        else res = b_r - a_r;
      end
      lpmq_pkg::ACT_DIV, lpmq_pkg::ACT_DIVS: begin
        if (zdiv_r) begin
          op_ov  = 1'b1;
          mq_nxt = '0;
        end else begin
          op_ov  = qneg ? ((|dq_r[2*W-1:W]) || (dq_r[W-1] && (|dq_r[W-2:0])))
                        : ((|dq_r[2*W-1:W]) || dq_r[W-1]);
          res    = qneg ? (~dq_r[W-1:0] + 1'b1) : dq_r[W-1:0];
          mq_nxt = dneg_r ? (~rem_r + 1'b1) : rem_r;
        end
      end
      lpmq_pkg::ACT_MUL: begin
        res    = prod[2*W-1:W];
        mq_nxt = prod[W-1:0];
        op_ov  = !((&prod[2*W-1:W-1]) || !(|prod[2*W-1:W-1]));
      end
      lpmq_pkg::ACT_WR_MQ: begin
        arith  = 1'b0;
        mq_nxt = a_r;
      end
      default: begin
        arith  = 1'b0;
        so_nxt = 1'b0;
      end
    endcase
    if (arith && upd_r) begin
      ov_nxt = op_ov;
      if (op_ov) so_nxt = 1'b1;
    end
    cr = '0;
    if (arith && rec_r) begin
      if (!op_ov) begin
        if (res == '0)      cr = lpmq_pkg::CR_EQ;
        else if (res[W-1])  cr = lpmq_pkg::CR_LT;
        else                cr = lpmq_pkg::CR_GT;
      end
      cr[0] = so_nxt;
    end
    out_nxt.result           = res;
    out_nxt.cr0              = cr;
    out_nxt.overflow         = ov_nxt;
    out_nxt.summary_overflow = so_nxt;
    out_nxt.mq_value         = mq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mq_r        <= '0;
      ov_r        <= 1'b0;
      so_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin_go) begin
        mq_r <= mq_nxt;
        ov_r <= ov_nxt;
        so_r <= so_nxt;
      end
      if (fin_go)           out_valid_r <= 1'b1;
      else if (!out_stall)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    if (accept) begin
      op_r   <= in_data.action;
      a_r    <= in_data.operand_a;
      b_r    <= (is_div || is_mul) && in_data.operand_b[W-1] ?
                (~in_data.operand_b + 1'b1) : in_data.operand_b;
      rec_r  <= in_data.record_cr;
      upd_r  <= in_data.update_ov;
      dneg_r <= is_mul ? in_data.operand_a[W-1] : dvd[2*W-1];
      vneg_r <= in_data.operand_b[W-1];
      zdiv_r <= (in_data.operand_b == '0);
    end
    if (fin_go) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted word did not start an operation");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished operation left no result word");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < 6'(W)))
    else $error("multiply step count out of range");

  a_clr_so: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && op_r == lpmq_pkg::ACT_CLR_SO) |=> !so_r)
    else $error("SO not cleared");

endmodule
